// ----- rtl/bmu_pkg.sv -----
package bmu_pkg;

   // blend mode codes
   localparam logic [3:0] MODE_ADD     = 4'd0;
   localparam logic [3:0] MODE_SUB     = 4'd1;
   localparam logic [3:0] MODE_MUL     = 4'd2;
   localparam logic [3:0] MODE_SCREEN  = 4'd3;
   localparam logic [3:0] MODE_RED     = 4'd4;
   localparam logic [3:0] MODE_GREEN   = 4'd5;
   localparam logic [3:0] MODE_BLUE    = 4'd6;
   localparam logic [3:0] MODE_AVERAGE = 4'd7;
   localparam logic [3:0] MODE_OVERLAY = 4'd8;
   localparam logic [3:0] MODE_LIGHTEN = 4'd9;
   localparam logic [3:0] MODE_DARKEN  = 4'd10;
   localparam logic [3:0] MODE_DODGE   = 4'd11;
   localparam logic [3:0] MODE_BURN    = 4'd12;

   // channel codes
   localparam logic [1:0] CHAN_RED   = 2'd0;
   localparam logic [1:0] CHAN_GREEN = 2'd1;
   localparam logic [1:0] CHAN_BLUE  = 2'd2;

   localparam logic [7:0]  FULL_SCALE = 8'd255;
   localparam logic [16:0] FULL_SQ    = 17'd65025;

   // divider bit positions handled by each stage, top bit first
   localparam logic [3:0] DIV_TOP_0 = 4'd8;
   localparam logic [3:0] DIV_TOP_1 = 4'd5;
   localparam logic [3:0] DIV_TOP_2 = 4'd2;

   typedef struct packed {
      logic [7:0] base_value;
      logic [7:0] blend_value;
      logic [1:0] channel_index;
      logic       last_pixel;
   } bmu_req_type;

   typedef struct packed {
      logic [7:0] out_value;
      logic       write_enable;
      logic       last_out;
   } bmu_rsp_type;

   // per-item control carried beside the divider
   typedef struct packed {
      logic       use_div;
      logic       dbl;
      logic       sat;
      logic       we;
      logic       last;
      logic [7:0] simple;
   } bmu_ctl_type;

   typedef struct packed {
      logic [16:0] rem;
      logic [8:0]  den;
      logic [8:0]  quo;
      logic        ovf;
   } bmu_div_type;

endpackage

// ----- rtl/bmu_prep.sv -----
module bmu_prep (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  bmu_pkg::bmu_req_type in_data,
   input  logic [3:0]           mode,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bmu_pkg::bmu_ctl_type out_ctl,
   output bmu_pkg::bmu_div_type out_div
);

   logic                 a_valid_ff;
   bmu_pkg::bmu_req_type a_req_ff;
   logic [3:0]           a_mode_ff;
   logic [15:0]          a_ab_ff;
   logic [15:0]          a_pp_ff;
   logic                 a_ready;

   logic                 b_valid_ff;
   bmu_pkg::bmu_ctl_type b_ctl_ff;
   bmu_pkg::bmu_div_type b_div_ff;
   logic                 b_ready;

   bmu_pkg::bmu_ctl_type b_ctl_in;
   bmu_pkg::bmu_div_type b_div_in;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // stage a: products
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
      if (a_ready && in_valid) begin
         a_req_ff  <= in_data;
         a_mode_ff <= mode;
         a_ab_ff   <= in_data.base_value * in_data.blend_value;
         a_pp_ff   <= (bmu_pkg::FULL_SCALE - in_data.base_value)
                      * (bmu_pkg::FULL_SCALE - in_data.blend_value);
      end
   end

   // stage b: simple results and divider operands
   always_comb begin
      logic [7:0]  a;
      logic [7:0]  b;
      logic [7:0]  ia;
      logic [7:0]  ib;
      logic [8:0]  sum;
      logic [9:0]  tri_sum;
      logic [16:0] scr_x;
      logic [16:0] ovl_x;
      logic [7:0]  diff;
      logic [16:0] num;
      logic [8:0]  den;
      a       = a_req_ff.base_value;
      b       = a_req_ff.blend_value;
      ia      = ~a;
      ib      = ~b;
      sum     = {1'b0, a} + {1'b0, b};
      tri_sum = {1'b0, a, 1'b0} + {2'b00, a} + {2'b00, b};
      scr_x   = bmu_pkg::FULL_SQ - {1'b0, a_pp_ff};
      ovl_x   = bmu_pkg::FULL_SQ - {a_pp_ff, 1'b0};
      diff    = a - ib;
      num     = {1'b0, a_ab_ff};
      den     = {1'b0, bmu_pkg::FULL_SCALE};
      b_ctl_in         = '0;
      b_ctl_in.we      = 1'b1;
      b_ctl_in.last    = a_req_ff.last_pixel;
      unique case (a_mode_ff)
         bmu_pkg::MODE_ADD: begin
            b_ctl_in.simple = sum[8] ? bmu_pkg::FULL_SCALE : sum[7:0];
         end
         bmu_pkg::MODE_SUB: begin
            b_ctl_in.simple = (a > b) ? (a - b) : 8'd0;
         end
         bmu_pkg::MODE_MUL: begin
            b_ctl_in.use_div = 1'b1;
         end
         bmu_pkg::MODE_SCREEN: begin
            b_ctl_in.use_div = 1'b1;
            num = {scr_x[15:0], 1'b0} + 17'd255;
            den = {bmu_pkg::FULL_SCALE, 1'b0};
         end
         bmu_pkg::MODE_RED, bmu_pkg::MODE_GREEN, bmu_pkg::MODE_BLUE: begin
            b_ctl_in.simple = (tri_sum > 10'd255) ? bmu_pkg::FULL_SCALE : tri_sum[7:0];
            b_ctl_in.we = (a_mode_ff == bmu_pkg::MODE_RED
                           && a_req_ff.channel_index == bmu_pkg::CHAN_RED)
                       || (a_mode_ff == bmu_pkg::MODE_GREEN
                           && a_req_ff.channel_index == bmu_pkg::CHAN_GREEN)
                       || (a_mode_ff == bmu_pkg::MODE_BLUE
                           && a_req_ff.channel_index == bmu_pkg::CHAN_BLUE);
         end
         bmu_pkg::MODE_AVERAGE: begin
            b_ctl_in.simple = sum[8:1];
         end
         bmu_pkg::MODE_OVERLAY: begin
            b_ctl_in.use_div = 1'b1;
            if (!b[7]) begin
               b_ctl_in.dbl = 1'b1;
            end else begin
               num = {ovl_x[15:0], 1'b0} + 17'd255;
               den = {bmu_pkg::FULL_SCALE, 1'b0};
            end
         end
         bmu_pkg::MODE_LIGHTEN: begin
            b_ctl_in.simple = (a > b) ? a : b;
         end
         bmu_pkg::MODE_DARKEN: begin
            b_ctl_in.simple = (a < b) ? a : b;
         end
         bmu_pkg::MODE_DODGE: begin
            if (a == bmu_pkg::FULL_SCALE) begin
               b_ctl_in.simple = bmu_pkg::FULL_SCALE;
            end else begin
               b_ctl_in.use_div = 1'b1;
               b_ctl_in.sat     = 1'b1;
               num = {b, 9'd0} - {8'd0, b, 1'b0} + {9'd0, ia};
               den = {ia, 1'b0};
            end
         end
         bmu_pkg::MODE_BURN: begin
            b_ctl_in.simple = 8'd0;
            if (a != 8'd0 && a > ib) begin
               b_ctl_in.use_div = 1'b1;
               num = {diff, 9'd0} - {8'd0, diff, 1'b0} + {9'd0, a};
               den = {a, 1'b0};
            end
         end
         default: begin
            b_ctl_in.we = 1'b0;
         end
      endcase
      b_div_in.rem = num;
      b_div_in.den = den;
      b_div_in.quo = '0;
      b_div_in.ovf = {1'b0, num} >= {den, 9'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_ready && a_valid_ff) begin
         b_ctl_ff <= b_ctl_in;
         b_div_ff <= b_div_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_ctl   = b_ctl_ff;
   assign out_div   = b_div_ff;

endmodule

// ----- rtl/bmu_div_stage.sv -----
module bmu_div_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [3:0]           top_bit,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  bmu_pkg::bmu_ctl_type in_ctl,
   input  bmu_pkg::bmu_div_type in_div,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bmu_pkg::bmu_ctl_type out_ctl,
   output bmu_pkg::bmu_div_type out_div
);

   logic                 valid_ff;
   bmu_pkg::bmu_ctl_type ctl_ff;
   bmu_pkg::bmu_div_type div_ff;
   bmu_pkg::bmu_div_type div_in;

   assign in_ready = !valid_ff || out_ready;

   // three restoring steps
   always_comb begin
      logic [3:0]  pos;
      logic [17:0] shifted;
      div_in = in_div;
      for (int k = 0; k < 3; k++) begin
         pos     = top_bit - 4'(k);
         shifted = {9'd0, in_div.den} << pos;
         if ({1'b0, div_in.rem} >= shifted) begin
            div_in.rem      = div_in.rem - shifted[16:0];
            div_in.quo[pos] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         ctl_ff <= in_ctl;
         div_ff <= div_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_div   = div_ff;

endmodule

// ----- rtl/pixel_blend_mode_unit.sv -----
// pixel_blend_mode_unit
// Blends one 8-bit colour channel word per clock, unless the receiver
// stalls, under the mode held in the blend mode register (written through
// csr_write_enable/csr_write_data, taken at once; the user writes it only
// while no word is in flight, and the block does not enforce this).
// Input words arrive on req_valid/req_ready/req_data, results leave on
// rsp_valid/rsp_ready/rsp_data, one result per input word, in order.
// Six register stages, the first loaded at the accepting edge: two operand
// stages, three divider stages of three quotient bits each, and one output
// register. One word per clock unless rsp_ready stalls; each stage holds
// its own valid bit and takes a new word when empty or its successor moves.
// The divider is a pipelined restoring divider shared by the multiply,
// screen, overlay, dodge and burn modes.
// Reset: clears all valid bits and sets the mode to add.
// When the receiver holds rsp_ready low, words pile into empty stages;
// once all six stages are full req_ready drops, and nothing is lost.
module pixel_blend_mode_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bmu_pkg::bmu_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bmu_pkg::bmu_rsp_type rsp_data,
   input  logic                 csr_write_enable,
   input  logic [3:0]           csr_write_data
);

   logic [3:0]           mode_ff;
   logic                 p_valid;
   logic                 p_ready;
   bmu_pkg::bmu_ctl_type p_ctl;
   bmu_pkg::bmu_div_type p_div;

   logic                 d_valid [3];
   logic                 d_ready [3];
   bmu_pkg::bmu_ctl_type d_ctl   [3];
   bmu_pkg::bmu_div_type d_div   [3];

   logic                 rsp_valid_ff;
   bmu_pkg::bmu_rsp_type rsp_data_ff;
   bmu_pkg::bmu_rsp_type rsp_data_in;
   logic                 out_ready;

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= bmu_pkg::MODE_ADD;
      end else if (csr_write_enable) begin
         mode_ff <= csr_write_data;
      end
   end

   bmu_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .mode      (mode_ff),
      .out_valid (p_valid),
      .out_ready (p_ready),
      .out_ctl   (p_ctl),
      .out_div   (p_div)
   );

   bmu_div_stage u_div0 (
      .clock     (clock),
      .reset     (reset),
      .top_bit   (bmu_pkg::DIV_TOP_0),
      .in_valid  (p_valid),
      .in_ready  (p_ready),
      .in_ctl    (p_ctl),
      .in_div    (p_div),
      .out_valid (d_valid[0]),
      .out_ready (d_ready[0]),
      .out_ctl   (d_ctl[0]),
      .out_div   (d_div[0])
   );

   bmu_div_stage u_div1 (
      .clock     (clock),
      .reset     (reset),
      .top_bit   (bmu_pkg::DIV_TOP_1),
      .in_valid  (d_valid[0]),
      .in_ready  (d_ready[0]),
      .in_ctl    (d_ctl[0]),
      .in_div    (d_div[0]),
      .out_valid (d_valid[1]),
      .out_ready (d_ready[1]),
      .out_ctl   (d_ctl[1]),
      .out_div   (d_div[1])
   );

   bmu_div_stage u_div2 (
      .clock     (clock),
      .reset     (reset),
      .top_bit   (bmu_pkg::DIV_TOP_2),
      .in_valid  (d_valid[1]),
      .in_ready  (d_ready[1]),
      .in_ctl    (d_ctl[1]),
      .in_div    (d_div[1]),
      .out_valid (d_valid[2]),
      .out_ready (d_ready[2]),
      .out_ctl   (d_ctl[2]),
      .out_div   (d_div[2])
   );

   assign out_ready  = !rsp_valid_ff || rsp_ready;
   assign d_ready[2] = out_ready;

   // final selection
   always_comb begin
      logic [7:0] value;
      if (!d_ctl[2].use_div) begin
         value = d_ctl[2].simple;
      end else if (d_ctl[2].sat && (d_div[2].ovf || d_div[2].quo[8])) begin
         value = bmu_pkg::FULL_SCALE;
      end else if (d_ctl[2].dbl) begin
         value = {d_div[2].quo[6:0], 1'b0};
      end else begin
         value = d_div[2].quo[7:0];
      end
      rsp_data_in.out_value    = d_ctl[2].we ? value : 8'd0;
      rsp_data_in.write_enable = d_ctl[2].we;
      rsp_data_in.last_out     = d_ctl[2].last;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= d_valid[2];
      end
      if (out_ready && d_valid[2]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // a word that is not written carries zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.write_enable |-> rsp_data.out_value == 8'd0)
      else $error("unwritten word carries a nonzero value");

   // an empty output stage lets the whole pipe move
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with an empty output stage");

   // input stalls only when every stage is full and the receiver stalls
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready && p_valid
                     && d_valid[0] && d_valid[1] && d_valid[2])
      else $error("input stalled while the pipe has room");

   // saturation only applies to words that use the divider
   assert property (@(posedge clock) disable iff (reset)
      d_valid[2] && d_ctl[2].sat |-> d_ctl[2].use_div)
      else $error("saturate flag without divider use");
`endif

endmodule
